### hdl/lic_pkg.sv
// ----------------------------------------------------------------------------
// lic_pkg: shared types and constants of the lever interlock checker
// Request codes, the stored condition entry and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lic_pkg;

    localparam int STATE_W = 32;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_MOVE    = 2'd1;
    localparam logic [1:0] REQ_ILLEGAL = 2'd2;

    localparam logic [5:0] LEVERS_USED_RESET = 6'd32;

    typedef struct packed {
        logic [5:0] target;
        logic       need;
        logic [5:0] alt;
        logic       alt_need;
    } t_cond;

    localparam int COND_W = $bits(t_cond);

    localparam t_cond COND_EMPTY = '{target: 6'h3F, need: 1'b0, alt: 6'h3F, alt_need: 1'b0};

    typedef struct packed {
        logic clear;
        logic write;
        logic load;
        logic others;
        logic next_lever;
        logic next_slot;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic phase_own;
        logic illegal;
        logic fail;
        logic stop;
        logic lever_end;
        logic lever_skip;
    } t_stat;

endpackage

### hdl/lic_ram.sv
// ----------------------------------------------------------------------------
// lic_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lic_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/lic_ctrl.sv
// ----------------------------------------------------------------------------
// lic_ctrl: sequencer of the lever interlock checker
// Runs the clearing pass, accepts words, steps the condition walk and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module lic_ctrl
    import lic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    output t_cmd       o_cmd,
    input  t_stat      i_stat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_verdict
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_RESULT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_verdict;
    logic   r_fail;

    logic   accept;
    logic   is_check;
    logic   done;
    logic   done_fail;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_check   = (i_req_type == REQ_MOVE) || (i_req_type == REQ_ILLEGAL);

    // Command decode: one step of the walk per cycle
    always_comb begin
        o_cmd     = '0;
        done      = 1'b0;
        done_fail = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_cmd.write = accept && (i_req_type == REQ_WRITE);
                o_cmd.load  = accept && is_check;
            end
            S_WALK: begin
                if (i_stat.phase_own) begin
                    priority if (i_stat.fail) begin
                        done      = 1'b1;
                        done_fail = 1'b1;
                    end else if (i_stat.stop) begin
                        o_cmd.others = 1'b1;
                    end else begin
                        o_cmd.next_slot = 1'b1;
                    end
                end else begin
                    priority if (i_stat.lever_end) begin
                        done = 1'b1;
                    end else if (i_stat.lever_skip) begin
                        o_cmd.next_lever = 1'b1;
                    end else if (i_stat.fail) begin
                        done      = 1'b1;
                        done_fail = 1'b1;
                    end else if (i_stat.stop) begin
                        o_cmd.next_lever = 1'b1;
                    end else begin
                        o_cmd.next_slot = 1'b1;
                    end
                end
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the taken word; in S_RESULT the reload below decides
            if (r_out_valid && i_out_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (done) begin
                        r_fail  <= done_fail;
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_verdict   <= i_stat.illegal ? r_fail : !r_fail;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

### hdl/lic_datapath.sv
// ----------------------------------------------------------------------------
// lic_datapath: condition table, walk counters and slot evaluation
// Holds the request, steps lever and slot counters on command and reports
// the test of the current table entry.
// ----------------------------------------------------------------------------
module lic_datapath
    import lic_pkg::*;
#(
    parameter int NUM_LEVERS           = 32,
    parameter int CONDITIONS_PER_LEVER = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [5:0]        i_cfg_wr_data,
    input  logic [1:0]        i_req_type,
    input  logic [4:0]        i_lever_index,
    input  logic [2:0]        i_slot,
    input  logic signed [5:0] i_target_lever,
    input  logic              i_target_required,
    input  logic signed [5:0] i_alt_lever,
    input  logic              i_alt_required,
    input  logic [31:0]       i_lever_states,
    input  logic              i_proposed_thrown,
    input  t_cmd              i_cmd,
    output t_stat             o_stat
);

    localparam int DEPTH  = NUM_LEVERS * CONDITIONS_PER_LEVER;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW    = $clog2(NUM_LEVERS + 1);
    localparam int SIW    = (CONDITIONS_PER_LEVER > 1) ? $clog2(CONDITIONS_PER_LEVER) : 1;
    localparam int CMPW   = (LCW > 6) ? LCW : 6;

    logic [5:0]        r_levers_used;
    logic [4:0]        r_idx;
    logic [31:0]       r_states;
    logic              r_sub;
    logic              r_illegal;
    logic              r_phase_own;
    logic [LCW-1:0]    r_lever;
    logic [SIW-1:0]    r_slot;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              n_phase_own;
    logic [LCW-1:0]    n_lever;
    logic [SIW-1:0]    n_slot;

    logic [31:0]       wr_full;
    logic [31:0]       rd_full;
    logic              wr_ok;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wa;
    t_cond             ram_wd;
    t_cond             wr_cond;
    logic [COND_W-1:0] ram_rd;
    t_cond             rd;

    logic              sub_in;
    logic              own_en;

    logic [CMPW-1:0]   lev_ext;
    logic              t_sub;
    logic              t_in;
    logic              t_val;
    logic              a_sub;
    logic              a_valid;
    logic              a_val;
    logic              alt_ok;
    logic              met;
    logic              names;
    logic              counted;

    // Table write: from the input word, or an empty entry during the clearing pass
    assign wr_full = 32'(i_lever_index) * 32'(CONDITIONS_PER_LEVER) + 32'(i_slot);
    assign wr_ok   = (32'(i_lever_index) < 32'(NUM_LEVERS))
                  && (32'(i_slot) < 32'(CONDITIONS_PER_LEVER));
    assign wr_cond = '{target: $unsigned(i_target_lever), need: i_target_required,
                       alt: $unsigned(i_alt_lever), alt_need: i_alt_required};
    assign ram_we  = i_cmd.clear || (i_cmd.write && wr_ok);
    assign ram_wa  = i_cmd.clear ? r_clr_addr : wr_full[ADDR_W-1:0];
    assign ram_wd  = i_cmd.clear ? COND_EMPTY : wr_cond;

    // Read at the next counter values so the data lines up with the registers
    assign rd_full = 32'(n_lever) * 32'(CONDITIONS_PER_LEVER) + 32'(n_slot);

    lic_ram #(
        .WIDTH (COND_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (rd_full[ADDR_W-1:0]),
        .o_rd_data (ram_rd)
    );

    assign rd = t_cond'(ram_rd);

    // Substituted state of the moving or checked lever
    assign sub_in = (i_req_type == REQ_MOVE) ? i_proposed_thrown : i_lever_states[i_lever_index];
    assign own_en = sub_in && (32'(i_lever_index) < 32'(NUM_LEVERS));

    always_comb begin
        n_phase_own = r_phase_own;
        n_lever     = r_lever;
        n_slot      = r_slot;
        if (i_cmd.load) begin
            n_phase_own = own_en;
            n_lever     = own_en ? LCW'(i_lever_index) : '0;
            n_slot      = '0;
        end
        if (i_cmd.others) begin
            n_phase_own = 1'b0;
            n_lever     = '0;
            n_slot      = '0;
        end
        if (i_cmd.next_lever) begin
            n_lever = r_lever + LCW'(1);
            n_slot  = '0;
        end
        if (i_cmd.next_slot) begin
            n_slot = r_slot + SIW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levers_used <= LEVERS_USED_RESET;
            r_phase_own   <= 1'b0;
            r_lever       <= '0;
            r_slot        <= '0;
            r_clr_addr    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_levers_used <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_phase_own <= n_phase_own;
            r_lever     <= n_lever;
            r_slot      <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx     <= i_lever_index;
            r_states  <= i_lever_states;
            r_sub     <= sub_in;
            r_illegal <= (i_req_type == REQ_ILLEGAL);
        end
    end

    // Slot test
    assign t_sub   = (rd.target[4:0] == r_idx);
    assign t_in    = ({1'b0, rd.target[4:0]} < r_levers_used);
    assign t_val   = t_sub ? r_sub : (t_in && r_states[rd.target[4:0]]);
    assign a_sub   = (rd.alt[4:0] == r_idx);
    assign a_valid = !rd.alt[5] && ({1'b0, rd.alt[4:0]} < r_levers_used);
    assign a_val   = a_sub ? r_sub : r_states[rd.alt[4:0]];
    assign alt_ok  = a_valid && (a_val == rd.alt_need);
    assign met     = (t_val == rd.need) || alt_ok;
    assign names   = t_sub || (!rd.alt[5] && a_sub);
    assign counted = !(r_illegal && !r_phase_own) || names;

    // Lever sweep bounds
    assign lev_ext = CMPW'(r_lever);

    assign o_stat.clear_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_stat.phase_own  = r_phase_own;
    assign o_stat.illegal    = r_illegal;
    assign o_stat.fail       = !rd.target[5] && counted && !met;
    assign o_stat.stop       = rd.target[5] || (r_slot == SIW'(CONDITIONS_PER_LEVER - 1));
    assign o_stat.lever_end  = !((lev_ext < CMPW'(r_levers_used))
                                 && (lev_ext < CMPW'(NUM_LEVERS)));
    assign o_stat.lever_skip = (lev_ext == CMPW'(r_idx))
                            || !((lev_ext < CMPW'(STATE_W)) && r_states[lev_ext[4:0]]);

endmodule

### hdl/lever_interlock_checker.sv
// ----------------------------------------------------------------------------
// lever_interlock_checker: interlocking condition checker for a lever frame
// Stores condition slots per lever and answers move checks and illegal
// checks against a word of lever states.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ---------------------------
//  cfg       in         i_cfg_wr_en (no wait)        i_cfg_wr_data (levers in use)
//  in        in         i_in_valid / o_in_ready      request word, nine fields
//  out       out        o_out_valid / i_out_ready    o_verdict
//
//  A write word goes straight into the table. A check word is loaded, walks
//  the condition slots of its own lever and of each other thrown lever,
//  skipping the rest, ends the sweep and passes into the output register;
//  the walk reads one table entry per cycle through the single read port
//  of the RAM. After reset a clearing pass empties the table; no word is
//  accepted meanwhile, config writes are. A result waits in the output
//  register while the next word is accepted; that word's result waits
//  until the register is taken.
// ----------------------------------------------------------------------------
module lever_interlock_checker
    import lic_pkg::*;
#(
    parameter int NUM_LEVERS           = 32,
    parameter int CONDITIONS_PER_LEVER = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [5:0]        i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [4:0]        i_lever_index,
    input  logic [2:0]        i_slot,
    input  logic signed [5:0] i_target_lever,
    input  logic              i_target_required,
    input  logic signed [5:0] i_alt_lever,
    input  logic              i_alt_required,
    input  logic [31:0]       i_lever_states,
    input  logic              i_proposed_thrown,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_verdict
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: clearing pass, word acceptance, walk steps, result register
    lic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_cmd       (cmd),
        .i_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (o_verdict)
    );

    // Datapath: condition table, lever and slot counters, slot test
    lic_datapath #(
        .NUM_LEVERS           (NUM_LEVERS),
        .CONDITIONS_PER_LEVER (CONDITIONS_PER_LEVER)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_req_type        (i_req_type),
        .i_lever_index     (i_lever_index),
        .i_slot            (i_slot),
        .i_target_lever    (i_target_lever),
        .i_target_required (i_target_required),
        .i_alt_lever       (i_alt_lever),
        .i_alt_required    (i_alt_required),
        .i_lever_states    (i_lever_states),
        .i_proposed_thrown (i_proposed_thrown),
        .i_cmd             (cmd),
        .o_stat            (stat)
    );

    // At most one counter or table command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.write, cmd.load, cmd.others, cmd.next_lever, cmd.next_slot}))
        else $error("lever_interlock_checker: conflicting datapath commands");

    // No word is taken while the walk advances
    a_walk_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.next_lever || cmd.next_slot || cmd.others) |-> !o_in_ready)
        else $error("lever_interlock_checker: ready during condition walk");

    // A check word starts a walk and closes the input
    a_check_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_req_type == REQ_MOVE || i_req_type == REQ_ILLEGAL))
        |=> !o_in_ready)
        else $error("lever_interlock_checker: input open after check accepted");

    // The clearing pass keeps the input closed
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (!o_in_ready && !cmd.write))
        else $error("lever_interlock_checker: word accepted during clearing pass");

endmodule

### tb/sv/lever_interlock_checker_test.sv
// ----------------------------------------------------------------------------
// lever_interlock_checker_test: self-checking bench of the interlock checker
// Drives write, move-check and illegal-check words with random idling on
// both sides, keeps its own copy of the condition table and lever count,
// and compares every verdict against the copy in order of acceptance.
// ----------------------------------------------------------------------------
module lever_interlock_checker_test
    import lic_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVERS    = 32;
    localparam int SLOTS     = 8;
    // Worst check walk: load, all own slots, every other lever fully walked,
    // output register. Pad it for the settle waits.
    localparam int WALK_WAIT = 2 + SLOTS + LEVERS * (SLOTS + 1) + 24;

    // Request code the block has no use for.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  lever;
        logic [2:0]  slot;
        logic [5:0]  target;
        logic        need;
        logic [5:0]  alt;
        logic        alt_need;
        logic [31:0] states;
        logic        proposed;
    } t_req_word;

    localparam int WORD_W = $bits(t_req_word);

    // ------------------------------------------------------------------
    // DUT ports, inputs all known from time zero
    // ------------------------------------------------------------------
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_wr_en       = 1'b0;
    logic [5:0]  i_cfg_wr_data     = '0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type        = REQ_WRITE;
    logic [4:0]  i_lever_index     = '0;
    logic [2:0]  i_slot            = '0;
    logic signed [5:0] i_target_lever = '0;
    logic        i_target_required = 1'b0;
    logic signed [5:0] i_alt_lever = '0;
    logic        i_alt_required    = 1'b0;
    logic [31:0] i_lever_states    = '0;
    logic        i_proposed_thrown = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready       = 1'b0;
    logic        o_verdict;

    // ------------------------------------------------------------------
    // Shadow state of the block
    // ------------------------------------------------------------------
    t_cond cond_table [LEVERS][SLOTS];
    int    levers_in_use = int'(LEVERS_USED_RESET);
    logic  verdicts_due [$];
    int    errors  = 0;
    bit    calm    = 1'b0;   // set for the final stretch: no idling at all
    int    stall_left = 0;

    lever_interlock_checker #(
        .NUM_LEVERS           (LEVERS),
        .CONDITIONS_PER_LEVER (SLOTS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_lever_index     (i_lever_index),
        .i_slot            (i_slot),
        .i_target_lever    (i_target_lever),
        .i_target_required (i_target_required),
        .i_alt_lever       (i_alt_lever),
        .i_alt_required    (i_alt_required),
        .i_lever_states    (i_lever_states),
        .i_proposed_thrown (i_proposed_thrown),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One slot: target or alternative must match. The lever under test
    // (sub) reads its substituted state; levers past the count read false,
    // and an alternative past the count is simply ignored.
    function automatic logic slot_met(t_cond c, logic [31:0] states, int sub, logic sub_st);
        int   tgt;
        int   alt;
        logic t;
        logic alt_ok;
        tgt = $signed(c.target);
        alt = $signed(c.alt);
        if (tgt < 0) return 1'b1;
        if (tgt == sub) t = sub_st;
        else if (tgt < levers_in_use && tgt < 32) t = states[tgt];
        else t = 1'b0;
        alt_ok = 1'b0;
        if (alt >= 0 && alt < levers_in_use)
            alt_ok = (((alt == sub) ? sub_st : ((alt < 32) && states[alt])) == c.alt_need);
        return (t == c.need) || alt_ok;
    endfunction

    // Walk one lever's slots up to the first empty one. With only_naming,
    // skip slots that mention neither target nor alternative as sub.
    function automatic logic lever_clear(int lev, logic [31:0] states, int sub,
                                         logic sub_st, bit only_naming);
        t_cond e;
        for (int c = 0; c < SLOTS; c++) begin
            e = cond_table[lev][c];
            if ($signed(e.target) < 0) break;
            if (only_naming && $signed(e.target) != sub && $signed(e.alt) != sub) continue;
            if (!slot_met(e, states, sub, sub_st)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Every other thrown lever in use must still hold with sub substituted.
    function automatic logic others_clear(logic [31:0] states, int sub, logic sub_st,
                                          bit only_naming);
        for (int i = 0; i < levers_in_use && i < LEVERS; i++) begin
            if (i == sub || !states[i]) continue;
            if (!lever_clear(i, states, sub, sub_st, only_naming)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic interlock_verdict(t_req_word w);
        logic thrown;
        logic hit;
        if (w.kind == REQ_MOVE) begin
            hit = 1'b1;
            if (w.proposed && !lever_clear(int'(w.lever), w.states, int'(w.lever), 1'b1, 1'b0))
                hit = 1'b0;
            if (hit && !others_clear(w.states, int'(w.lever), w.proposed, 1'b0))
                hit = 1'b0;
        end else begin
            thrown = w.states[w.lever];
            hit = 1'b0;
            if (thrown && !lever_clear(int'(w.lever), w.states, int'(w.lever), thrown, 1'b0))
                hit = 1'b1;
            if (!hit && !others_clear(w.states, int'(w.lever), thrown, 1'b1))
                hit = 1'b1;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Word builders; unused fields carry noise
    // ------------------------------------------------------------------
    function automatic t_req_word write_word(int lev, int slot, int tgt, logic need,
                                             int alt, logic alt_need);
        t_req_word w;
        w          = t_req_word'(WORD_W'({$urandom, $urandom}));
        w.kind     = REQ_WRITE;
        w.lever    = lev[4:0];
        w.slot     = slot[2:0];
        w.target   = tgt[5:0];
        w.need     = need;
        w.alt      = alt[5:0];
        w.alt_need = alt_need;
        return w;
    endfunction

    function automatic t_req_word check_word(logic [1:0] kind, int lev,
                                             logic [31:0] states, logic prop);
        t_req_word w;
        w          = t_req_word'(WORD_W'({$urandom, $urandom}));
        w.kind     = kind;
        w.lever    = lev[4:0];
        w.states   = states;
        w.proposed = prop;
        return w;
    endfunction

    // Levers cluster in the low eight so the table gets dense there.
    function automatic int near_lever();
        return ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 7))
                                          : int'($urandom_range(0, 31));
    endfunction

    function automatic int pick_ref();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 12) return -int'($urandom_range(1, 32));
        if (r < 75) return int'($urandom_range(0, 7));
        return int'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_states();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return '0;
            3:       return '1;
            4:       return $urandom & $urandom & $urandom;
            default: return $urandom & 32'hFF;
        endcase
    endfunction

    function automatic t_req_word draw_word();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 30)
            return write_word(near_lever(), int'($urandom_range(0, 7)), pick_ref(),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 9) < 4) ? -1 : pick_ref(),
                              1'($urandom_range(0, 1)));
        if (r < 62)
            return check_word(REQ_MOVE, near_lever(), pick_states(),
                              1'($urandom_range(0, 1)));
        if (r < 95)
            return check_word(REQ_ILLEGAL, near_lever(), pick_states(),
                              1'($urandom_range(0, 1)));
        return check_word(REQ_UNUSED, int'($urandom_range(0, 31)), $urandom,
                          1'($urandom_range(0, 1)));
    endfunction

    function automatic int sender_gap();
        if (calm) return 0;
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Send one word; update the shadow at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_word(input t_req_word w);
        int gap;
        i_in_valid        <= 1'b1;
        i_req_type        <= w.kind;
        i_lever_index     <= w.lever;
        i_slot            <= w.slot;
        i_target_lever    <= w.target;
        i_target_required <= w.need;
        i_alt_lever       <= w.alt;
        i_alt_required    <= w.alt_need;
        i_lever_states    <= w.states;
        i_proposed_thrown <= w.proposed;
        do @(posedge i_clk); while (!o_in_ready);
        // word taken at this edge
        if (w.kind == REQ_WRITE)
            cond_table[w.lever][w.slot] = '{target: w.target, need: w.need,
                                            alt: w.alt, alt_need: w.alt_need};
        else if (w.kind == REQ_MOVE || w.kind == REQ_ILLEGAL)
            verdicts_due.push_back(interlock_verdict(w));
        gap = sender_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, let every verdict come home and any trailing write or
    // unused word finish its walk.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (WALK_WAIT) @(posedge i_clk);
    endtask

    // Change the number of levers in use only with the block quiet.
    task automatic set_levers_used(input int n);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n[5:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        levers_in_use = n & 6'h3F;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, then steady once calm
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= int'($urandom_range(0, 5));
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each taken verdict with the oldest one due.
    always @(posedge i_clk) begin
        logic due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t ns: verdict with none due, expected none actual %0b",
                         $time, o_verdict);
                errors++;
            end else begin
                due = verdicts_due.pop_front();
                if (o_verdict !== due) begin
                    $display("%0t ns: verdict mismatch, expected %0b actual %0b",
                             $time, due, o_verdict);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: every move allowed, nothing illegal; unused code ignored.
    task automatic test_empty_table();
        send_word(check_word(REQ_MOVE, 0, '0, 1'b1));
        send_word(check_word(REQ_MOVE, 31, '1, 1'b0));
        send_word(check_word(REQ_ILLEGAL, 31, '1, 1'b0));
        send_word(check_word(REQ_UNUSED, 7, '1, 1'b1));
    endtask

    // Lever 1 needs lever 0 thrown, then lever 31 normal or lever 2 thrown;
    // an empty slot ends its list, so the slot behind it never counts.
    // Lever 31 needs lever 1 normal.
    task automatic test_conditions();
        send_word(write_word(1, 0, 0, 1'b1, -1, 1'b0));
        send_word(write_word(1, 1, 31, 1'b0, 2, 1'b1));
        send_word(write_word(1, 2, -32, 1'b1, 31, 1'b1));
        send_word(write_word(1, 3, 5, 1'b1, -1, 1'b0));
        send_word(write_word(31, 7, 31, 1'b1, 31, 1'b1));
        send_word(write_word(31, 0, 1, 1'b0, -1, 1'b0));
        send_word(check_word(REQ_MOVE, 1, 32'h0000_0000, 1'b1));
        send_word(check_word(REQ_MOVE, 1, 32'h0000_0001, 1'b1));
        send_word(check_word(REQ_MOVE, 1, 32'h8000_0001, 1'b1));
        send_word(check_word(REQ_MOVE, 1, 32'h8000_0005, 1'b1));
        send_word(check_word(REQ_MOVE, 0, 32'h0000_0002, 1'b0));
        send_word(check_word(REQ_ILLEGAL, 0, 32'h0000_0002, 1'b0));
        send_word(check_word(REQ_ILLEGAL, 1, 32'h0000_0003, 1'b0));
        send_word(check_word(REQ_ILLEGAL, 1, 32'h8000_0002, 1'b0));
        send_word(check_word(REQ_MOVE, 31, 32'h0000_0002, 1'b1));
    endtask

    // Levers at or past the count: targets read false, alternatives drop out.
    task automatic test_levers_used_limits();
        set_levers_used(1);
        send_word(check_word(REQ_MOVE, 1, 32'h0000_0005, 1'b1));
        send_word(check_word(REQ_ILLEGAL, 0, 32'h0000_0003, 1'b0));
        set_levers_used(0);
        send_word(check_word(REQ_MOVE, 1, 32'h0000_0001, 1'b1));
        set_levers_used(63);
        send_word(check_word(REQ_MOVE, 31, 32'h0000_0000, 1'b1));
    endtask

    task automatic test_random_traffic(input int count, input int n);
        set_levers_used(count);
        repeat (n) send_word(draw_word());
    endtask

    // Last stretch: full rate on both sides.
    task automatic test_back_to_back(input int n);
        set_levers_used(LEVERS);
        calm = 1'b1;
        repeat (n) send_word(draw_word());
    endtask

    initial begin
        for (int l = 0; l < LEVERS; l++)
            for (int c = 0; c < SLOTS; c++)
                cond_table[l][c] = COND_EMPTY;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_conditions();
        test_levers_used_limits();
        test_random_traffic(32, 120);
        test_random_traffic(5, 80);
        test_random_traffic(0, 40);
        test_random_traffic(63, 60);
        test_random_traffic(20, 80);
        test_back_to_back(100);

        settle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### lever_interlock_checker.f
hdl/lic_pkg.sv
hdl/lic_ram.sv
hdl/lic_ctrl.sv
hdl/lic_datapath.sv
hdl/lever_interlock_checker.sv
tb/sv/lever_interlock_checker_test.sv
